// File: src/pqam_pkg.sv
`default_nettype none

package pqam_pkg;

  // Sizes of the fixed fields.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int ADDR_W          = 64;
  localparam int POS_W           = 5;
  localparam int MODE_W          = 3;
  localparam int IN_TDATA_W      = 3 * ADDR_W;
  localparam int OUT_TDATA_W     = ((POS_W + 2 * ADDR_W + 7) / 8) * 8;

  // Operation codes carried in the input word's tuser.
  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PAGE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EVICT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FREE   = 3'd5;

  // Event time of an empty slot.
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  // One slot of the ring.
  typedef struct packed {
    logic [ADDR_W-1:0] line_addr;
    logic [ADDR_W-1:0] byte_addr;
    logic [ADDR_W-1:0] ready_time;
  } pqam_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the accepted input word
    logic load_single;  // operation without a scan, result loaded
    logic scan_start;   // set up a slot scan
    logic scan_run;     // issue one read and compare the previous one
    logic finish;       // apply the scan outcome, result loaded
  } pqam_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              empty;
    logic              scan_done;
  } pqam_stat_t;

endpackage

`default_nettype wire

// File: src/pqam_ctrl.sv
`default_nettype none

module pqam_ctrl
  import pqam_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_valid,
  output logic            s_ready,
  output logic            m_valid,
  input  wire logic       m_ready,
  input  wire pqam_stat_t stat,
  output pqam_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DISPATCH = 2'd1;
  localparam logic [1:0] ST_SCAN     = 2'd2;
  localparam logic [1:0] ST_FINISH   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       is_scan;

  // The result register may be loaded when empty or being emptied this cycle.
  assign out_free = !m_valid || m_ready;
  assign s_ready  = (state == ST_IDLE);

  // Operations that walk the slots; lookups on an empty ring miss at once.
  always_comb begin
    unique case (stat.mode) inside
      MODE_EVICT, MODE_FREE:  is_scan = 1'b1;
      MODE_LOOKUP, MODE_PAGE: is_scan = !stat.empty;
      default:                is_scan = 1'b0;
    endcase
  end

  // Sequencing of one word.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (is_scan) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else if (out_free) begin
          cmd.load_single = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          if (out_free) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_FINISH;
          end
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.load_single || cmd.finish) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: src/pqam_dpath.sv
`default_nettype none

module pqam_dpath
  import pqam_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pqam_cmd_t              cmd,
  output pqam_stat_t                  stat,
  input  wire logic [IN_TDATA_W-1:0]  s_data,
  input  wire logic [MODE_W-1:0]      s_user,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata,
  output logic      [OUT_TDATA_W-1:0] m_data,
  output logic                        m_user
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PAD_W = OUT_TDATA_W - POS_W - 2 * ADDR_W;
  localparam logic [PTR_W-1:0] LAST_IDX  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(QUEUE_DEPTH % (2 ** POS_W));

  // Configuration and captured word.
  logic              match_full;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] key_line;
  logic [ADDR_W-1:0] key_byte;
  logic [ADDR_W-1:0] key_time;

  // Ring control.
  logic [PTR_W-1:0]       head;
  logic [PTR_W-1:0]       tail;
  logic [CNT_W-1:0]       fill;
  logic [QUEUE_DEPTH-1:0] valid;
  pqam_entry_t            mem [QUEUE_DEPTH];

  // Scan engine.
  pqam_entry_t       rd_entry;
  logic              rd_valid;
  logic              cmp_pending;
  logic [PTR_W-1:0]  cmp_idx;
  logic [PTR_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  scan_left;
  logic              hit;
  logic [PTR_W-1:0]  hit_idx;
  logic [ADDR_W-1:0] hit_time;
  logic [ADDR_W-1:0] best_time;
  logic [ADDR_W-1:0] best_line;

  // Result register.
  logic              res_ok;
  logic [POS_W-1:0]  res_pos;
  logic [ADDR_W-1:0] res_time;
  logic [ADDR_W-1:0] res_addr;

  logic              push_go;
  logic              pop_go;
  logic              evict_go;
  logic              free_go;
  logic              full;
  logic [CNT_W-1:0]  span_cnt;
  logic [ADDR_W-1:0] eff_line;
  logic [ADDR_W-1:0] eff_byte;
  logic [ADDR_W-1:0] eff_time;
  logic              cmp_match;

  function automatic logic [POS_W-1:0] to_pos(input logic [PTR_W-1:0] p);
    logic [PTR_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, p};
    return ext[POS_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign full     = (fill >= DEPTH_CNT);
  assign push_go  = cmd.load_single && (mode == MODE_PUSH) && !full;
  assign pop_go   = cmd.load_single && (mode == MODE_POP) && (fill != '0);
  assign evict_go = cmd.finish && (mode == MODE_EVICT) && hit;
  assign free_go  = cmd.finish && (mode == MODE_FREE) && hit;

  // Number of slots in the live span, head up to just before tail.
  assign span_cnt = (head < tail) ? CNT_W'(tail) - CNT_W'(head)
                                  : DEPTH_CNT - CNT_W'(head) + CNT_W'(tail);

  // A slot that is not valid reads as a cleared slot.
  assign eff_line = rd_valid ? rd_entry.line_addr  : '0;
  assign eff_byte = rd_valid ? rd_entry.byte_addr  : '0;
  assign eff_time = rd_valid ? rd_entry.ready_time : ALL_ONES;

  // Match test of the slot read in the previous cycle.
  always_comb begin
    unique case (mode)
      MODE_LOOKUP: cmp_match = match_full ? (eff_byte == key_byte) : (eff_line == key_line);
      MODE_PAGE:   cmp_match = (eff_line == key_line);
      MODE_FREE:   cmp_match = (eff_line == '0);
      default:     cmp_match = 1'b0;
    endcase
  end

  assign stat.mode      = mode;
  assign stat.empty     = (head == tail) && (fill == '0);
  assign stat.scan_done = ((scan_left == '0) && !cmp_pending)
                          || (hit && (mode != MODE_EVICT));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_full <= 1'b0;
    end else if (cfg_we) begin
      match_full <= cfg_wdata;
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode     <= s_user;
      key_line <= s_data[ADDR_W-1:0];
      key_byte <= s_data[2*ADDR_W-1:ADDR_W];
      key_time <= s_data[3*ADDR_W-1:2*ADDR_W];
    end
  end

  // Slot memory: one write port for pushes, one registered read port for scans.
  always_ff @(posedge clk) begin
    if (push_go) begin
      mem[tail] <= '{line_addr: key_line, byte_addr: key_byte, ready_time: key_time};
    end
    if (cmd.scan_run) begin
      rd_entry <= mem[scan_idx];
      rd_valid <= valid[scan_idx];
    end
  end

  // Pointers, occupancy and slot valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      fill  <= '0;
      valid <= '0;
    end else begin
      if (push_go) begin
        valid[tail] <= 1'b1;
        fill        <= fill + 1'b1;
        tail        <= wrap_inc(tail);
      end
      if (pop_go) begin
        valid[head] <= 1'b0;
        fill        <= fill - 1'b1;
        head        <= wrap_inc(head);
      end
      if (evict_go) begin
        valid[hit_idx] <= 1'b0;
        if (fill != '0) begin
          fill <= fill - 1'b1;
        end
      end
      if (free_go) begin
        tail <= hit_idx;
      end
    end
  end

  // Scan: one read issued per cycle, the previous read compared alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pending <= 1'b0;
      hit         <= 1'b0;
      scan_left   <= '0;
    end else if (cmd.scan_start) begin
      scan_idx    <= (mode == MODE_LOOKUP) ? head : '0;
      scan_left   <= (mode == MODE_LOOKUP) ? span_cnt : DEPTH_CNT;
      cmp_pending <= 1'b0;
      hit         <= 1'b0;
      best_time   <= ALL_ONES;
    end else if (cmd.scan_run) begin
      if (scan_left != '0) begin
        scan_idx    <= wrap_inc(scan_idx);
        scan_left   <= scan_left - 1'b1;
        cmp_idx     <= scan_idx;
        cmp_pending <= 1'b1;
      end else begin
        cmp_pending <= 1'b0;
      end
      if (cmp_pending) begin
        if (mode == MODE_EVICT) begin
          // Strictly smaller keeps the lowest slot among equal times.
          if (eff_time < best_time) begin
            best_time <= eff_time;
            best_line <= eff_line;
            hit_idx   <= cmp_idx;
            hit       <= 1'b1;
          end
        end else if (cmp_match && !hit) begin
          hit      <= 1'b1;
          hit_idx  <= cmp_idx;
          hit_time <= eff_time;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      res_time <= '0;
      res_addr <= '0;
      unique case (mode)
        MODE_PUSH: begin
          res_ok  <= !full;
          res_pos <= to_pos(tail);
        end
        MODE_POP: begin
          res_ok  <= (fill != '0);
          res_pos <= (fill != '0) ? to_pos(head) : '0;
        end
        default: begin
          res_ok  <= 1'b0;
          res_pos <= '0;
        end
      endcase
    end else if (cmd.finish) begin
      res_ok   <= hit;
      res_pos  <= hit ? to_pos(hit_idx) : '0;
      res_time <= '0;
      res_addr <= '0;
      unique case (mode)
        MODE_PAGE: begin
          res_time <= hit ? hit_time : '0;
        end
        MODE_EVICT: begin
          res_addr <= hit ? best_line : '0;
        end
        MODE_FREE: begin
          res_pos <= hit ? to_pos(hit_idx) : DEPTH_POS;
        end
        default: begin
          res_ok <= hit;
        end
      endcase
    end
  end

  assign m_data = {{PAD_W{1'b0}}, res_addr, res_time, res_pos};
  assign m_user = res_ok;

endmodule

`default_nettype wire

// File: src/packet_queue_with_address_match_core.sv
// Request ring of QUEUE_DEPTH slots (line address, byte address, event time)
// with head, tail and occupancy, and address search over its slots.
// Input words: s_axis_tuser carries the operation (push, pop, lookup, page
// lookup, evict oldest, find free); s_axis_tdata carries the addresses and
// the event time. Every input word yields exactly one output word on the
// m_axis group: tuser is the success flag, tdata the slot position, the
// event time of a page lookup hit and the line address of an evicted slot.
// cfg_we/cfg_wdata set the lookup compare: 1 full byte address, 0 line address.
// One word is in flight at a time. Push, pop and no-operation words, and lookups
// on an empty ring, load the result register in the dispatch state after acceptance,
// once it is free. Searching words walk the slots through the single read port
// of the slot memory, one slot per cycle (the live span for lookup, QUEUE_DEPTH
// slots otherwise; lookup, page lookup and find free stop at the first hit).
// The next word is accepted in the cycle after the result is loaded.
// Reset empties the ring at once: slot valid bits are cleared, pointers and
// occupancy go to zero, no sweep is needed. A stalled receiver holds the
// output word; a finished word then waits until the result register frees up,
// and no input word is accepted meanwhile. One new input word can be accepted
// while the previous output word is still held.
`default_nettype none

module packet_queue_with_address_match_core
  import pqam_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // line_address, byte_address, ready_time
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  wire logic [MODE_W-1:0]      s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // position, found_time, evicted_address, zero padding
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // ok
  output logic                        m_axis_tuser,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_wdata
);

  pqam_cmd_t  cmd;
  pqam_stat_t stat;

  pqam_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  pqam_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_data    (s_axis_tdata),
    .s_user    (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_data    (m_axis_tdata),
    .m_user    (m_axis_tuser)
  );

  // Only one word is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input word accepted while another is in flight");

  // A result never overwrites a word the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_single || cmd.finish) |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result register overwritten while stalled");

  // Controller issues at most one command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.load_single, cmd.scan_start, cmd.scan_run, cmd.finish}))
    else $error("conflicting datapath commands");

  // Scans start only for searching operations.
  a_scan_mode: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> (stat.mode == MODE_LOOKUP || stat.mode == MODE_PAGE ||
                        stat.mode == MODE_EVICT || stat.mode == MODE_FREE))
    else $error("scan started for a non-searching operation");

endmodule

`default_nettype wire

// File: bench/packet_queue_with_address_match_core_test.sv
`default_nettype none

module packet_queue_with_address_match_core_test
  import pqam_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 2_000_000;

  // Modes 6 and 7 carry no operation.
  localparam logic [MODE_W-1:0] MODE_NOP_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NOP_B = 3'd7;

  // Settings of the lookup compare register.
  localparam logic MATCH_LINE = 1'b0;
  localparam logic MATCH_BYTE = 1'b1;

  // One result word as the ring should produce it.
  typedef struct packed {
    logic              ok;
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] found_time;
    logic [ADDR_W-1:0] evicted;
  } ring_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_we = 1'b0;
  logic                   cfg_wdata = 1'b0;

  // Shadow copy of the ring and its compare setting.
  logic [ADDR_W-1:0] ring_line [DEPTH];
  logic [ADDR_W-1:0] ring_byte [DEPTH];
  logic [ADDR_W-1:0] ring_time [DEPTH];
  int                ring_head;
  int                ring_tail;
  int                ring_fill;
  logic              cmp_full;

  ring_result_t      pending_results[$];
  int                error_count = 0;
  int                word_count = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  logic [ADDR_W-1:0] line_pool [8];
  logic [ADDR_W-1:0] byte_pool [8];

  packet_queue_with_address_match_core #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Empty slots hold zero addresses and an all-ones event time.
  function automatic void clear_slot(int i);
    ring_line[i] = '0;
    ring_byte[i] = '0;
    ring_time[i] = ALL_ONES;
  endfunction

  function automatic logic slot_hit(int i, logic [ADDR_W-1:0] line_addr,
                                    logic [ADDR_W-1:0] byte_addr);
    if (cmp_full) begin
      return ring_byte[i] == byte_addr;
    end
    return ring_line[i] == line_addr;
  endfunction

  // Applies one input word to the shadow ring and returns its result.
  function automatic ring_result_t ring_apply(logic [MODE_W-1:0] mode,
                                              logic [ADDR_W-1:0] line_addr,
                                              logic [ADDR_W-1:0] byte_addr,
                                              logic [ADDR_W-1:0] rtime);
    ring_result_t      r;
    int                stop;
    int                oldest;
    logic [ADDR_W-1:0] best;
    logic              empty;
    r = '0;
    empty = (ring_head == ring_tail) && (ring_fill == 0);
    case (mode)
      MODE_PUSH: begin
        r.pos = POS_W'(ring_tail);
        if (ring_fill < DEPTH) begin
          ring_line[ring_tail] = line_addr;
          ring_byte[ring_tail] = byte_addr;
          ring_time[ring_tail] = rtime;
          r.ok = 1'b1;
          ring_fill++;
          ring_tail = (ring_tail + 1) % DEPTH;
        end
      end
      MODE_POP: begin
        if (ring_fill != 0) begin
          clear_slot(ring_head);
          r.pos = POS_W'(ring_head);
          r.ok = 1'b1;
          ring_fill--;
          ring_head = (ring_head + 1) % DEPTH;
        end
      end
      MODE_LOOKUP: begin
        // The live span runs from the head, wrapping past the last slot.
        if (!empty) begin
          stop = (ring_head < ring_tail) ? ring_tail : DEPTH;
          for (int i = ring_head; i < stop && !r.ok; i++) begin
            if (slot_hit(i, line_addr, byte_addr)) begin
              r.ok = 1'b1;
              r.pos = POS_W'(i);
            end
          end
          if (ring_head >= ring_tail) begin
            for (int i = 0; i < ring_tail && !r.ok; i++) begin
              if (slot_hit(i, line_addr, byte_addr)) begin
                r.ok = 1'b1;
                r.pos = POS_W'(i);
              end
            end
          end
        end
      end
      MODE_PAGE: begin
        if (!empty) begin
          for (int i = 0; i < DEPTH && !r.ok; i++) begin
            if (ring_line[i] == line_addr) begin
              r.ok = 1'b1;
              r.pos = POS_W'(i);
              r.found_time = ring_time[i];
            end
          end
        end
      end
      MODE_EVICT: begin
        // The lowest slot with the smallest time below all ones goes.
        best = ALL_ONES;
        oldest = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (ring_time[i] < best) begin
            best = ring_time[i];
            oldest = i;
          end
        end
        if (oldest >= 0) begin
          r.evicted = ring_line[oldest];
          clear_slot(oldest);
          if (ring_fill != 0) begin
            ring_fill--;
          end
          r.ok = 1'b1;
          r.pos = POS_W'(oldest);
        end
      end
      MODE_FREE: begin
        r.pos = POS_W'(DEPTH);
        for (int i = 0; i < DEPTH && !r.ok; i++) begin
          if (ring_line[i] == '0) begin
            ring_tail = i;
            r.pos = POS_W'(i);
            r.ok = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    error_count++;
    $display("word %0d: %s is %h, %h was due", word_count, field, got, want);
  endtask

  // Receiver: stalls at random, in the share that the current phase sets.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each output word is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[ADDR_W-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.ok) begin
          report_mismatch("ok", ADDR_W'(m_axis_tuser), ADDR_W'(want.ok));
        end
        if (m_axis_tdata[POS_W-1:0] !== want.pos) begin
          report_mismatch("position", ADDR_W'(m_axis_tdata[POS_W-1:0]),
                          ADDR_W'(want.pos));
        end
        if (m_axis_tdata[POS_W +: ADDR_W] !== want.found_time) begin
          report_mismatch("found_time", m_axis_tdata[POS_W +: ADDR_W],
                          want.found_time);
        end
        if (m_axis_tdata[POS_W+ADDR_W +: ADDR_W] !== want.evicted) begin
          report_mismatch("evicted_address", m_axis_tdata[POS_W+ADDR_W +: ADDR_W],
                          want.evicted);
        end
      end
      word_count++;
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("packet_queue_with_address_match_core: mismatch");
    $finish;
  end

  // Offers one word, after a random gap, and records its expected result.
  task automatic send_word(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] line_addr,
                           logic [ADDR_W-1:0] byte_addr, logic [ADDR_W-1:0] rtime);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {rtime, byte_addr, line_addr};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(ring_apply(mode, line_addr, byte_addr, rtime));
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic wait_ring_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only with the ring idle.
  task automatic write_match_mode(logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cmp_full = value;
    cfg_we <= 1'b0;
  endtask

  // Empty ring cases, no-operation modes, filling to the brim and beyond.
  task automatic test_directed();
    logic [ADDR_W-1:0] line_addr;
    write_match_mode(MATCH_LINE);
    send_word(MODE_POP, '0, '0, '0);
    send_word(MODE_LOOKUP, ALL_ONES, ALL_ONES, '0);
    send_word(MODE_PAGE, '0, '0, '0);
    send_word(MODE_EVICT, '0, '0, '0);
    send_word(MODE_FREE, '0, '0, '0);
    send_word(MODE_NOP_A, ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(MODE_NOP_B, '0, '0, '0);
    for (int i = 0; i < DEPTH; i++) begin
      line_addr = 64'h40 + 64'h1000 * ADDR_W'(i);
      if (i == 0) begin
        send_word(MODE_PUSH, ALL_ONES, ALL_ONES, ALL_ONES);
      end else begin
        send_word(MODE_PUSH, line_addr, (line_addr << 6) | ADDR_W'(i),
                  (i == DEPTH - 1) ? '0 : 64'd100 - ADDR_W'(i));
      end
    end
    send_word(MODE_PUSH, 64'h5, 64'h5, 64'h5);
    send_word(MODE_FREE, '0, '0, '0);
    wait_ring_idle();
  endtask

  // Both compare settings, page lookup, eviction and a wrapped live span.
  task automatic test_lookup_modes();
    send_word(MODE_LOOKUP, 64'h5040, rand64(), '0);
    wait_ring_idle();
    write_match_mode(MATCH_BYTE);
    send_word(MODE_LOOKUP, 64'h3040, (64'h7040 << 6) | 64'd7, '0);
    send_word(MODE_LOOKUP, 64'h3040, 64'h0123, '0);
    send_word(MODE_PAGE, 64'h9040, '0, '0);
    send_word(MODE_EVICT, '0, '0, '0);
    send_word(MODE_POP, '0, '0, '0);
    send_word(MODE_PUSH, 64'hABCD_0000, 64'hFEED_BEEF, 64'd3);
    send_word(MODE_LOOKUP, '0, 64'hFEED_BEEF, '0);
    wait_ring_idle();
  endtask

  function automatic void refresh_pools();
    line_pool[0] = '0;
    line_pool[1] = ALL_ONES;
    byte_pool[0] = '0;
    byte_pool[1] = ALL_ONES;
    for (int k = 2; k < 8; k++) begin
      line_pool[k] = rand64();
      byte_pool[k] = rand64();
    end
  endfunction

  // One random word; addresses come mostly from a small pool so that
  // lookups hit, and pushes thin out as the ring fills.
  task automatic send_random_word();
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] line_addr;
    logic [ADDR_W-1:0] byte_addr;
    logic [ADDR_W-1:0] rtime;
    int                k;
    int                pick;
    int                push_cut;
    int                pop_cut;
    k = $urandom_range(7);
    line_addr = ($urandom_range(99) < 80) ? line_pool[k] : rand64();
    pick = $urandom_range(99);
    if (pick < 70) begin
      byte_addr = byte_pool[k];
    end else if (pick < 85) begin
      byte_addr = byte_pool[$urandom_range(7)];
    end else begin
      byte_addr = rand64();
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      rtime = ALL_ONES;
    end else if (pick < 40) begin
      rtime = ADDR_W'($urandom_range(15));
    end else begin
      rtime = rand64();
    end
    push_cut = (ring_fill >= DEPTH - 2) ? 20 : 40;
    pop_cut  = push_cut + ((ring_fill >= DEPTH - 2) ? 30 : 15);
    pick = $urandom_range(99);
    if (pick < push_cut) begin
      mode = MODE_PUSH;
    end else if (pick < pop_cut) begin
      mode = MODE_POP;
    end else if (pick < pop_cut + 16) begin
      mode = MODE_LOOKUP;
    end else if (pick < pop_cut + 26) begin
      mode = MODE_PAGE;
    end else if (pick < pop_cut + 33) begin
      mode = MODE_EVICT;
    end else if (pick < pop_cut + 40) begin
      mode = MODE_FREE;
    end else begin
      mode = $urandom_range(1) ? MODE_NOP_A : MODE_NOP_B;
    end
    send_word(mode, line_addr, byte_addr, rtime);
  endtask

  // Random traffic in two halves, with the ring drained and the compare
  // setting changed between them.
  task automatic test_random_traffic(int send_pct, int recv_pct, logic first_mode,
                                     int words);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    refresh_pools();
    for (int half = 0; half < 2; half++) begin
      write_match_mode(half == 0 ? first_mode : ~first_mode);
      for (int n = 0; n < words / 2; n++) begin
        send_random_word();
      end
      wait_ring_idle();
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      clear_slot(i);
    end
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    cmp_full  = MATCH_LINE;
    send_idle_pct = 9;
    recv_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_lookup_modes();
    test_random_traffic(9, 79, MATCH_BYTE, 460);
    test_random_traffic(79, 9, MATCH_LINE, 460);
    test_random_traffic(0, 0, logic'($urandom_range(1)), 460);

    wait_ring_idle();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("outstanding results", ADDR_W'(pending_results.size()), '0);
    end
    if (error_count == 0) begin
      $display("packet_queue_with_address_match_core: match");
    end else begin
      $display("packet_queue_with_address_match_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
